[sv/assert_macros.svh]
// Assertion macros shared by the quadrature position controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, skipped while reset is low
`define QP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent / consequent form
`define QP_ASSERT_IMP(lbl, ante, cons, msg) \
	`QP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[sv/qppid_pkg.sv]
// Types, codes and constants of the quadrature position controller
`timescale 1ns / 1ps
package qppid_pkg;

	typedef struct packed {
		logic [1:0] func;
		logic       enc_a;
		logic       enc_b;
	} qppid_in_t;

	typedef struct packed {
		logic [13:0]        fwd_level;
		logic [13:0]        rev_level;
		logic signed [15:0] applied_drive;
		logic signed [31:0] encoder_total;
		logic signed [31:0] angle_now;
	} qppid_out_t;

	// input function codes
	localparam logic [1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_ZERO   = 2'd2;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_NOP,
		OP_STEP,
		OP_TICK,
		OP_ZERO
	} op_code_t;

	typedef struct packed {
		op_code_t          code;
		logic signed [1:0] delta;
	} qppid_op_t;

	localparam int unsigned QUEUE_DEPTH = 2;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_DRIVE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DEG_PER_CNT = 3'd7;

	localparam logic signed [23:0] RST_GAIN_P      = 24'sd13107;
	localparam logic signed [23:0] RST_GAIN_I      = 24'sd0;
	localparam logic signed [23:0] RST_GAIN_D      = 24'sd655;
	localparam logic [14:0]        RST_OUT_LIMIT   = 15'd24320;
	localparam logic signed [31:0] RST_DEG_PER_CNT = 32'sd6445889;

	localparam logic signed [15:0] FULL_DRIVE = 16'sd25600;
	localparam logic signed [31:0] SUM_LIMIT  = 32'sd327680000;

	// quadrature transition table, index = {last A, last B, A, B}
	function automatic logic signed [1:0] quad_step(input logic [3:0] t);
		logic signed [1:0] s;
		case (t)
			4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
			default: s = 2'sd0;
		endcase
		return s;
	endfunction

endpackage

[sv/qppid_front.sv]
// Front end: tracks the last A/B levels and classifies each input word
`timescale 1ns / 1ps
module qppid_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qppid_pkg::qppid_in_t  in_word,
	input  logic                  take,
	output qppid_pkg::qppid_op_t  op
);
	import qppid_pkg::*;

	logic [1:0] last_ab_q;

	always_comb begin
		op.code  = OP_NOP;
		op.delta = 2'sd0;
		case (in_word.func)
			FUNC_SAMPLE: begin
				op.code  = OP_STEP;
				op.delta = quad_step({last_ab_q, in_word.enc_a, in_word.enc_b});
			end
			FUNC_TICK: op.code = OP_TICK;
			FUNC_ZERO: op.code = OP_ZERO;
			default:   op.code = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ab_q <= 2'b00;
		end else if (take && (in_word.func == FUNC_SAMPLE || in_word.func == FUNC_ZERO)) begin
			last_ab_q <= {in_word.enc_a, in_word.enc_b};
		end
	end

endmodule

[sv/qppid_fifo.sv]
// Short operation queue between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qppid_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  qppid_pkg::qppid_op_t  push_op,
	input  logic                  pop,
	output qppid_pkg::qppid_op_t  head,
	output logic                  full,
	output logic                  empty
);
	import qppid_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	qppid_op_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`QP_ASSERT_IMP(a_fifo_no_overflow, push && full, pop, "push into full queue")
	`QP_ASSERT_IMP(a_fifo_no_underflow, pop, !empty, "pop from empty queue")

endmodule

[sv/qppid_back.sv]
// Back end: count update, angle, PID sequencer and PWM level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qppid_back #(
	parameter int unsigned PWM_TOP      = 9999,
	parameter int unsigned TICK_RATE_HZ = 100
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [qppid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qppid_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               q_empty,
	input  qppid_pkg::qppid_op_t               q_head,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output qppid_pkg::qppid_out_t              out_word
);
	import qppid_pkg::*;

	localparam int unsigned RATE     = (TICK_RATE_HZ < 1) ? 1 : TICK_RATE_HZ;
	localparam int unsigned RATE_W   = $clog2(RATE + 1);
	localparam int unsigned HALF     = RATE / 2;
	localparam int unsigned DIV_W    = 33;
	localparam int unsigned DR_W     = 33 + RATE_W + 1 + 8;
	localparam int unsigned U_W      = 65;
	localparam int unsigned TOP_W    = $clog2(PWM_TOP + 1);
	localparam int unsigned MP_W     = 15 + TOP_W + 1;
	localparam int unsigned X_W      = MP_W - 10;
	localparam int unsigned QP_W     = X_W + 22;
	localparam int unsigned LV_W     = QP_W - 26;
	// 2^26 / 25 rounded up; exact for the quotients seen here
	localparam logic [21:0] RECIP    = 22'd2684355;

	// ceil(2^REC_SH / RATE): floor quotient is exact for numerators below 2^32
	localparam int unsigned      REC_SH     = 32 + $clog2(RATE);
	localparam longint unsigned  REC_M      =
		((64'd1 << REC_SH) + 64'(RATE) - 64'd1) / 64'(RATE);
	localparam logic [32:0]      RATE_RECIP = 33'(REC_M);

	localparam logic signed [RATE_W:0]  RATE_S  = (RATE_W + 1)'(RATE);
	localparam logic signed [DR_W-1:0]  DER_MAX = DR_W'(64'sd549755813888);
	localparam logic signed [DR_W-1:0]  DER_MIN = -DER_MAX;

	typedef enum logic [3:0] {
		S_IDLE, S_AMUL, S_ANG, S_ERR, S_PREP, S_DIV, S_QUO, S_MUL1,
		S_MUL2, S_ACC, S_FIN, S_LV1, S_LV2
	} state_t;

	// configuration registers
	logic               loop_mode_q;
	logic signed [23:0] gain_p_q, gain_i_q, gain_d_q;
	logic [14:0]        limit_q;
	logic signed [31:0] target_q;
	logic signed [15:0] open_q;
	logic signed [31:0] dpc_q;

	// controller state
	state_t             state_q;
	logic signed [31:0] count_q, esum_q, lerr_q;
	logic               lerr_valid_q;
	logic signed [15:0] drive_q;
	logic               pid_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] angle_q, err_q, sum_new_q;
	logic signed [32:0] diff_q;
	logic [DIV_W-1:0]   num_q;
	logic [48:0]        pl_q;
	logic [47:0]        ph_q;
	logic               err_neg_q;
	logic signed [55:0] mp_q, mi_q;
	logic signed [40:0] der_q;
	logic signed [44:0] mdh_q, mdl_q;
	logic signed [U_W-1:0] u_q;
	logic [X_W-1:0]     x_q;
	logic               out_valid_q;
	qppid_out_t         out_q;

	logic cfg_clr;
	assign cfg_clr = cfg_we && (cfg_index == REG_LOOP_MODE || cfg_index == REG_GAIN_P
		|| cfg_index == REG_GAIN_I || cfg_index == REG_GAIN_D);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_mode_q <= 1'b0;
			gain_p_q    <= RST_GAIN_P;
			gain_i_q    <= RST_GAIN_I;
			gain_d_q    <= RST_GAIN_D;
			limit_q     <= RST_OUT_LIMIT;
			target_q    <= '0;
			open_q      <= '0;
			dpc_q       <= RST_DEG_PER_CNT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOOP_MODE:   loop_mode_q <= cfg_data[0];
				REG_GAIN_P:      gain_p_q    <= cfg_data[23:0];
				REG_GAIN_I:      gain_i_q    <= cfg_data[23:0];
				REG_GAIN_D:      gain_d_q    <= cfg_data[23:0];
				REG_OUT_LIMIT:   limit_q     <= cfg_data[14:0];
				REG_TARGET:      target_q    <= cfg_data[31:0];
				REG_OPEN_DRIVE:  open_q      <= cfg_data[15:0];
				REG_DEG_PER_CNT: dpc_q       <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// ---- datapath terms ----
	logic signed [15:0] open_clamped;
	assign open_clamped = (open_q > FULL_DRIVE) ? FULL_DRIVE :
		(open_q < -FULL_DRIVE) ? -FULL_DRIVE : open_q;

	logic signed [63:0] ang_rnd;
	logic signed [31:0] ang_sat;
	assign ang_rnd = (prod_q + 64'sd128) >>> 8;
	assign ang_sat = (ang_rnd > 64'sd2147483647) ? 32'sh7FFFFFFF :
		(ang_rnd < -64'sd2147483648) ? 32'sh80000000 : ang_rnd[31:0];

	logic signed [32:0] e33;
	logic signed [31:0] err_sat;
	assign e33     = 33'(target_q) - 33'(angle_q);
	assign err_sat = (e33[32] != e33[31]) ? (e33[32] ? 32'sh80000000 : 32'sh7FFFFFFF)
		: e33[31:0];

	logic [DIV_W-1:0] err_abs;
	assign err_abs = err_q[31] ? DIV_W'(-33'(err_q)) : DIV_W'(33'(err_q));

	// quotient of the reciprocal product, split in two partial products
	logic [65:0] qprod;
	assign qprod = (66'(pl_q) + (66'(ph_q) << 17)) >> REC_SH;

	logic signed [33:0] sq;
	logic signed [34:0] sum_raw;
	logic signed [31:0] sum_clamped;
	assign sq      = err_neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
	assign sum_raw = 35'(esum_q) + 35'(sq);
	assign sum_clamped = (sum_raw > 35'(SUM_LIMIT)) ? SUM_LIMIT :
		(sum_raw < -35'(SUM_LIMIT)) ? -SUM_LIMIT : sum_raw[31:0];

	logic signed [DR_W-1:0] dr;
	logic signed [40:0]     der_clamped;
	assign dr = DR_W'(diff_q) * DR_W'(RATE_S);
	assign der_clamped = (dr > DER_MAX) ? DER_MAX[40:0] :
		(dr < DER_MIN) ? DER_MIN[40:0] : dr[40:0];

	logic signed [55:0] mp, mi;
	logic signed [44:0] mdh, mdl;
	assign mp  = 56'(gain_p_q) * 56'(err_q);
	assign mi  = 56'(gain_i_q) * 56'(sum_new_q);
	assign mdh = 45'(gain_d_q) * 45'($signed(der_q[40:20]));
	assign mdl = 45'(gain_d_q) * 45'($signed({1'b0, der_q[19:0]}));

	logic signed [U_W-1:0] u_sum, u_rnd, lim_s;
	logic [14:0]           lim_eff;
	logic signed [15:0]    drive_pid;
	assign u_sum   = U_W'(mp_q) + U_W'(mi_q) + (U_W'(mdh_q) <<< 20) + U_W'(mdl_q);
	assign u_rnd   = (u_q + U_W'(64'sd8388608)) >>> 24;
	assign lim_eff = (limit_q > 15'(FULL_DRIVE)) ? 15'(FULL_DRIVE) : limit_q;
	assign lim_s   = $signed({{(U_W - 15){1'b0}}, lim_eff});
	assign drive_pid = (u_rnd > lim_s) ? lim_s[15:0] :
		(u_rnd < -lim_s) ? 16'(-lim_s) : u_rnd[15:0];

	logic [14:0]       mag;
	logic [MP_W-1:0]   lprod;
	logic [QP_W-1:0]   qp;
	logic [LV_W-1:0]   lvl_raw, lvl_cap;
	logic [13:0]       lvl;
	assign mag     = drive_q[15] ? 15'(-drive_q) : 15'(drive_q);
	assign lprod   = MP_W'(mag) * MP_W'(PWM_TOP) + MP_W'(12800);
	assign qp      = QP_W'(x_q) * QP_W'(RECIP);
	assign lvl_raw = qp[QP_W-1:26];
	assign lvl_cap = (lvl_raw > LV_W'(PWM_TOP)) ? LV_W'(PWM_TOP) : lvl_raw;
	assign lvl     = 14'(lvl_cap);

	logic out_load;
	assign out_load = (state_q == S_LV2) && (!out_valid_q || !out_stall);
	assign q_pop    = (state_q == S_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			esum_q       <= '0;
			lerr_q       <= '0;
			lerr_valid_q <= 1'b0;
			drive_q      <= '0;
			pid_q        <= 1'b0;
			prod_q       <= '0;
			angle_q      <= '0;
			err_q        <= '0;
			sum_new_q    <= '0;
			diff_q       <= '0;
			num_q        <= '0;
			pl_q         <= '0;
			ph_q         <= '0;
			err_neg_q    <= 1'b0;
			mp_q         <= '0;
			mi_q         <= '0;
			der_q        <= '0;
			mdh_q        <= '0;
			mdl_q        <= '0;
			u_q          <= '0;
			x_q          <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) out_valid_q <= 1'b0;
			if (cfg_clr) begin
				esum_q       <= '0;
				lerr_q       <= '0;
				lerr_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						pid_q <= (q_head.code == OP_TICK) && loop_mode_q;
						case (q_head.code)
							OP_STEP: count_q <= count_q + 32'(q_head.delta);
							OP_ZERO: begin
								count_q      <= '0;
								esum_q       <= '0;
								lerr_q       <= '0;
								lerr_valid_q <= 1'b0;
							end
							OP_TICK: if (!loop_mode_q) drive_q <= open_clamped;
							default: ;
						endcase
						state_q <= S_AMUL;
					end
				end
				S_AMUL: begin
					prod_q  <= count_q * dpc_q;
					state_q <= S_ANG;
				end
				S_ANG: begin
					angle_q <= ang_sat;
					state_q <= pid_q ? S_ERR : S_LV1;
				end
				S_ERR: begin
					err_q   <= err_sat;
					state_q <= S_PREP;
				end
				S_PREP: begin
					num_q     <= err_abs + DIV_W'(HALF);
					err_neg_q <= err_q[31];
					diff_q    <= 33'(err_q) - 33'(lerr_q);
					state_q   <= S_DIV;
				end
				S_DIV: begin
					// |e| + rate/2 times the reciprocal, low and high halves
					pl_q    <= 49'(num_q[31:0]) * 49'(RATE_RECIP[16:0]);
					ph_q    <= 48'(num_q[31:0]) * 48'(RATE_RECIP[32:17]);
					state_q <= S_QUO;
				end
				S_QUO: begin
					num_q   <= qprod[DIV_W-1:0];
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					mp_q      <= mp;
					der_q     <= lerr_valid_q ? der_clamped : '0;
					sum_new_q <= sum_clamped;
					state_q   <= S_MUL2;
				end
				S_MUL2: begin
					mi_q    <= mi;
					mdh_q   <= mdh;
					mdl_q   <= mdl;
					state_q <= S_ACC;
				end
				S_ACC: begin
					u_q     <= u_sum;
					state_q <= S_FIN;
				end
				S_FIN: begin
					drive_q      <= drive_pid;
					esum_q       <= sum_new_q;
					lerr_q       <= err_q;
					lerr_valid_q <= 1'b1;
					state_q      <= S_LV1;
				end
				S_LV1: begin
					x_q     <= lprod[MP_W-1:10];
					state_q <= S_LV2;
				end
				S_LV2: begin
					if (out_load) begin
						out_q.fwd_level     <= (drive_q > 16'sd0) ? lvl : 14'd0;
						out_q.rev_level     <= (drive_q < 16'sd0) ? lvl : 14'd0;
						out_q.applied_drive <= drive_q;
						out_q.encoder_total <= count_q;
						out_q.angle_now     <= angle_q;
						out_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	`QP_ASSERT(a_esum_bound, esum_q <= SUM_LIMIT && esum_q >= -SUM_LIMIT, "integral out of range")
	`QP_ASSERT(a_drive_bound, drive_q <= FULL_DRIVE && drive_q >= -FULL_DRIVE, "drive out of range")
	`QP_ASSERT_IMP(a_load_shows, out_load, ##1 out_valid_q, "loaded result not shown")

endmodule

[sv/quadrature_position_pid_hbridge_pwm.sv]
// Top level of the quadrature encoder position controller with PWM drive
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   in_word  (func, enc_a, enc_b)
// out       source     out_valid/out_stall out_word (levels, drive, count, angle)
// cfg       sink       cfg_we              cfg_index, cfg_data
//
// Encoder samples, zero requests and open-mode ticks pass these back-end steps
// (count update, angle multiply, round, level scale, level divide).
// Closed-loop ticks pass the same steps plus error, prep, a two-step
// reciprocal multiply for I += e / TICK_RATE_HZ, two multiply steps, sum, writeback.
// The front end and a 2-word queue keep taking words while the back end runs;
// in_stall is high only when that queue is full.
// The result register holds one word; the back end waits in its last step
// while that word is stalled.
// Reset (arst_n low, async) clears count, PID memory, drive and all handshakes;
// configuration registers return to their defaults.
module quadrature_position_pid_hbridge_pwm #(
	parameter int unsigned PWM_TOP      = 9999,
	parameter int unsigned TICK_RATE_HZ = 100
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  qppid_pkg::qppid_in_t               in_word,
	output logic                               out_valid,
	input  logic                               out_stall,
	output qppid_pkg::qppid_out_t              out_word,
	input  logic                               cfg_we,
	input  logic [qppid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qppid_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import qppid_pkg::*;

	logic      take;
	logic      q_full, q_empty, q_pop;
	qppid_op_t front_op, q_head;

	// a word is taken whenever the queue has room
	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	qppid_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_word (in_word),
		.take    (take),
		.op      (front_op)
	);

	qppid_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (take),
		.push_op (front_op),
		.pop     (q_pop),
		.head    (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	qppid_back #(
		.PWM_TOP      (PWM_TOP),
		.TICK_RATE_HZ (TICK_RATE_HZ)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
